[design/qoc_pkg.sv]
// qoc_pkg: shared types, constants and helpers for the quadratic outline to cubic path unit
// used by the front end, the command queue, the back end, the top level and the checker
`default_nettype none

package qoc_pkg;

	// path command codes
	typedef enum logic [1:0] {
		CMD_MOVETO  = 2'd0,
		CMD_LINETO  = 2'd1,
		CMD_CURVETO = 2'd2
	} cmd_t;

	// command queue between front and back end
	localparam int OPQ_DEPTH = 4;
	localparam int OPQ_AW    = $clog2(OPQ_DEPTH);
	localparam int OPQ_CW    = $clog2(OPQ_DEPTH + 1);

	// result queue at the output
	localparam int RESQ_DEPTH = 4;
	localparam int RESQ_AW    = $clog2(RESQ_DEPTH);
	localparam int RESQ_CW    = $clog2(RESQ_DEPTH + 1);

	// divide by six: bias makes the dividend non-negative, reciprocal is ceil(2^22 / 6)
	localparam int          DIV_W       = 19;
	localparam int          RECIP_W     = 20;
	localparam int          PROD_W      = DIV_W + RECIP_W;
	localparam int          RECIP_SHIFT = 22;
	localparam int          QUOT_W      = PROD_W - RECIP_SHIFT;
	localparam logic [DIV_W-1:0]   DIV_BIAS = 19'd196608;
	localparam logic [RECIP_W-1:0] RECIP6   = 20'd699051;

	// one command as decided by the front end, coordinates still unrounded
	// px/py: start anchor (doubled) of a curve, or the target of a moveto/lineto
	typedef struct packed {
		cmd_t               cmd;
		logic               last;
		logic signed [16:0] px;
		logic signed [16:0] py;
		logic signed [15:0] qx;
		logic signed [15:0] qy;
		logic signed [16:0] ex;
		logic signed [16:0] ey;
	} op_t;

	// up to two commands written per accepted point, v1 only with v0
	typedef struct packed {
		logic v0;
		logic v1;
		op_t  op0;
		op_t  op1;
	} op_wr_t;

	// command queue status
	typedef struct packed {
		logic full;
		logic nonempty;
	} opq_stat_t;

	// finished result
	typedef struct packed {
		cmd_t        cmd;
		logic [15:0] c1x;
		logic [15:0] c1y;
		logic [15:0] c2x;
		logic [15:0] c2y;
		logic [15:0] ex;
		logic [15:0] ey;
		logic        last;
	} res_t;

	function automatic op_t make_op(
		input cmd_t               cmd,
		input logic               last,
		input logic signed [16:0] px,
		input logic signed [16:0] py,
		input logic signed [15:0] qx,
		input logic signed [15:0] qy,
		input logic signed [16:0] ex,
		input logic signed [16:0] ey
	);
		op_t o;
		o.cmd  = cmd;
		o.last = last;
		o.px   = px;
		o.py   = py;
		o.qx   = qx;
		o.qy   = qy;
		o.ex   = ex;
		o.ey   = ey;
		return o;
	endfunction

endpackage

`default_nettype wire

[design/quadratic_outline_to_cubic_path_unit.sv]
// quadratic_outline_to_cubic_path_unit: top level, front end, command queue and back end
// depends on qoc_pkg, qoc_front, qoc_op_queue, qoc_back
//
//  channel   handshake        payload
//  points    push / full      point_x, point_y, on_curve, contour_end
//  results   pop / empty      command, ctrl1_x/y, ctrl2_x/y, end_x/y, last
//
// a point is taken every cycle while full is low; each point yields zero, one or two commands
// the back end retires one command per cycle while the result queue can take all in flight
// a command passes the command queue, the sum and multiply stages and the result queue to the ports
// full rises when the four-entry command queue has fewer than two free slots
// reset clears contour state and both queues at once, no clearing pass
`default_nettype none

module quadratic_outline_to_cubic_path_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_y,
	input  logic               on_curve,
	input  logic               contour_end,
	input  logic               push,
	output logic               full,
	output logic [1:0]         command,
	output logic signed [15:0] ctrl1_x,
	output logic signed [15:0] ctrl1_y,
	output logic signed [15:0] ctrl2_x,
	output logic signed [15:0] ctrl2_y,
	output logic signed [15:0] end_x,
	output logic signed [15:0] end_y,
	output logic               last,
	output logic               empty,
	input  logic               pop
);
	import qoc_pkg::*;

	op_wr_t    wr;
	op_t       head;
	opq_stat_t stat;
	logic      accept;
	logic      opq_pop;
	res_t      res;

	assign accept = push && !stat.full;
	assign full   = stat.full;

	// point classification and contour state
	qoc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_x     (point_x),
		.point_y     (point_y),
		.on_curve    (on_curve),
		.contour_end (contour_end),
		.accept      (accept),
		.wr          (wr)
	);

	// decoupling queue
	qoc_op_queue u_op_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.pop    (opq_pop),
		.head   (head),
		.stat   (stat)
	);

	// arithmetic and result queue
	qoc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.stat    (stat),
		.opq_pop (opq_pop),
		.pop     (pop),
		.res     (res),
		.empty   (empty)
	);

	// result ports
	assign command = res.cmd;
	assign ctrl1_x = res.c1x;
	assign ctrl1_y = res.c1y;
	assign ctrl2_x = res.c2x;
	assign ctrl2_y = res.c2y;
	assign end_x   = res.ex;
	assign end_y   = res.ey;
	assign last    = res.last;

endmodule

`default_nettype wire

[design/qoc_front.sv]
// qoc_front: accepts outline points, keeps the contour state and classifies each point
// into zero, one or two path commands; depends on qoc_pkg
`default_nettype none

module qoc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic signed [15:0]   point_x,
	input  logic signed [15:0]   point_y,
	input  logic                 on_curve,
	input  logic                 contour_end,
	input  logic                 accept,
	output qoc_pkg::op_wr_t      wr
);
	import qoc_pkg::*;

	logic signed [15:0] first_x_q, first_y_q;
	logic signed [16:0] anchor_x_q, anchor_y_q;
	logic signed [15:0] pend_x_q, pend_y_q;
	logic               pend_v_q;
	logic               start_q;

	logic signed [16:0] pt_x2, pt_y2, pt_xs, pt_ys;
	logic signed [16:0] mid_x, mid_y;
	logic signed [15:0] first_nx, first_ny;
	logic signed [16:0] first_x2, first_y2;

	logic               a_v;
	op_t                a_op;
	logic signed [16:0] anc_ax, anc_ay;
	logic signed [15:0] pend_ax, pend_ay;
	logic               pend_av;
	op_t                b_op;

	// point in doubled and sign-extended forms, midpoint with the pending control
	assign pt_x2    = {point_x, 1'b0};
	assign pt_y2    = {point_y, 1'b0};
	assign pt_xs    = {point_x[15], point_x};
	assign pt_ys    = {point_y[15], point_y};
	assign mid_x    = {pend_x_q[15], pend_x_q} + pt_xs;
	assign mid_y    = {pend_y_q[15], pend_y_q} + pt_ys;
	assign first_nx = start_q ? point_x : first_x_q;
	assign first_ny = start_q ? point_y : first_y_q;
	assign first_x2 = {first_nx, 1'b0};
	assign first_y2 = {first_ny, 1'b0};

	// command caused by the point itself
	always_comb begin
		a_v     = 1'b0;
		a_op    = '0;
		anc_ax  = anchor_x_q;
		anc_ay  = anchor_y_q;
		pend_ax = pend_x_q;
		pend_ay = pend_y_q;
		pend_av = pend_v_q;
		if (start_q) begin
			a_v     = 1'b1;
			a_op    = make_op(CMD_MOVETO, !contour_end, pt_xs, pt_ys, '0, '0, '0, '0);
			anc_ax  = pt_x2;
			anc_ay  = pt_y2;
			pend_av = 1'b0;
		end else if (on_curve) begin
			a_v = 1'b1;
			if (pend_v_q) begin
				a_op = make_op(CMD_CURVETO, !contour_end, anchor_x_q, anchor_y_q,
					pend_x_q, pend_y_q, pt_x2, pt_y2);
			end else begin
				a_op = make_op(CMD_LINETO, !contour_end, pt_xs, pt_ys, '0, '0, '0, '0);
			end
			anc_ax  = pt_x2;
			anc_ay  = pt_y2;
			pend_av = 1'b0;
		end else begin
			if (pend_v_q) begin
				a_v    = 1'b1;
				a_op   = make_op(CMD_CURVETO, !contour_end, anchor_x_q, anchor_y_q,
					pend_x_q, pend_y_q, mid_x, mid_y);
				anc_ax = mid_x;
				anc_ay = mid_y;
			end
			pend_ax = point_x;
			pend_ay = point_y;
			pend_av = 1'b1;
		end
	end

	// closing command at contour end, built on the state left by the first command
	always_comb begin
		if (pend_av) begin
			b_op = make_op(CMD_CURVETO, 1'b1, anc_ax, anc_ay, pend_ax, pend_ay,
				first_x2, first_y2);
		end else begin
			b_op = make_op(CMD_LINETO, 1'b1, {first_nx[15], first_nx},
				{first_ny[15], first_ny}, '0, '0, '0, '0);
		end
	end

	// pack into queue slots, oldest first
	always_comb begin
		wr.v0  = accept && (a_v || contour_end);
		wr.v1  = accept && a_v && contour_end;
		wr.op0 = a_v ? a_op : b_op;
		wr.op1 = b_op;
	end

	// contour state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x_q  <= '0;
			first_y_q  <= '0;
			anchor_x_q <= '0;
			anchor_y_q <= '0;
			pend_x_q   <= '0;
			pend_y_q   <= '0;
			pend_v_q   <= 1'b0;
			start_q    <= 1'b1;
		end else if (accept) begin
			first_x_q  <= first_nx;
			first_y_q  <= first_ny;
			anchor_x_q <= contour_end ? first_x2 : anc_ax;
			anchor_y_q <= contour_end ? first_y2 : anc_ay;
			pend_x_q   <= pend_ax;
			pend_y_q   <= pend_ay;
			pend_v_q   <= pend_av && !contour_end;
			start_q    <= contour_end;
		end
	end

endmodule

`default_nettype wire

[design/qoc_op_queue.sv]
// qoc_op_queue: short command queue between front and back end, two writes and one read
// per cycle; depends on qoc_pkg
`default_nettype none

module qoc_op_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  qoc_pkg::op_wr_t      wr,
	input  logic                 pop,
	output qoc_pkg::op_t         head,
	output qoc_pkg::opq_stat_t   stat
);
	import qoc_pkg::*;

	op_t               mem [OPQ_DEPTH];
	logic [OPQ_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [OPQ_CW-1:0] count_q;
	logic [OPQ_AW-1:0] n_wr;
	logic [OPQ_AW-1:0] wr_ptr_p1;

	assign n_wr      = OPQ_AW'({1'b0, wr.v0}) + OPQ_AW'({1'b0, wr.v1});
	assign wr_ptr_p1 = wr_ptr_q + OPQ_AW'(1);

	// storage
	always_ff @(posedge clk) begin
		if (wr.v0) begin
			mem[wr_ptr_q] <= wr.op0;
		end
		if (wr.v1) begin
			mem[wr_ptr_p1] <= wr.op1;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_wr;
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OPQ_AW'(1);
			end
			count_q <= count_q + OPQ_CW'(n_wr) - OPQ_CW'(pop);
		end
	end

	// full while fewer than two slots are free
	assign head          = mem[rd_ptr_q];
	assign stat.full     = count_q > OPQ_CW'(OPQ_DEPTH - 2);
	assign stat.nonempty = count_q != '0;

endmodule

`default_nettype wire

[design/qoc_back.sv]
// qoc_back: turns queued commands into path results, rounding curves through a
// sum, multiply and round pipeline, and holds them in the result queue; depends on qoc_pkg
`default_nettype none

module qoc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  qoc_pkg::op_t         head,
	input  qoc_pkg::opq_stat_t   stat,
	output logic                 opq_pop,
	input  logic                 pop,
	output qoc_pkg::res_t        res,
	output logic                 empty
);
	import qoc_pkg::*;

	// biased 4q + p, always in [0, 2^19)
	function automatic logic [DIV_W-1:0] biased_sum(
		input logic signed [15:0] q,
		input logic signed [16:0] p
	);
		logic [DIV_W-1:0] q4;
		logic [DIV_W-1:0] ps;
		q4 = {q[15], q, 2'b00};
		ps = {{2{p[16]}}, p};
		return q4 + ps + DIV_BIAS;
	endfunction

	// nearest, ties to even, from the biased quotient and the low dividend bits
	function automatic logic [15:0] round6(
		input logic [QUOT_W-1:0] qb,
		input logic [2:0]        nlo
	);
		logic [5:0]        m6;
		logic [2:0]        r;
		logic              up;
		logic [QUOT_W-1:0] s;
		m6 = {3'b000, qb[2:0]} * 6'd6;
		r  = nlo - m6[2:0];
		up = (r > 3'd3) || ((r == 3'd3) && qb[0]);
		s  = qb + QUOT_W'(up);
		return s[15:0] ^ 16'h8000;
	endfunction

	// half of a doubled value, ties to even
	function automatic logic [15:0] round2(input logic signed [16:0] e);
		logic [15:0] h;
		h = e[16:1];
		return h + 16'(e[0] && h[0]);
	endfunction

	logic                 valid_s1, valid_s2;
	cmd_t                 cmd_s1, cmd_s2;
	logic                 last_s1, last_s2;
	logic [DIV_W-1:0]     n1x_s1, n1y_s1, n2x_s1, n2y_s1;
	logic signed [16:0]   ex_s1, ey_s1, ex_s2, ey_s2;
	logic [15:0]          tx_s1, ty_s1, tx_s2, ty_s2;
	logic [QUOT_W-1:0]    q1x_s2, q1y_s2, q2x_s2, q2y_s2;
	logic [2:0]           l1x_s2, l1y_s2, l2x_s2, l2y_s2;
	logic [PROD_W-1:0]    p1x, p1y, p2x, p2y;

	res_t                 res_mem [RESQ_DEPTH];
	logic [RESQ_AW-1:0]   rq_wr_q, rq_rd_q;
	logic [RESQ_CW-1:0]   rq_cnt_q;
	logic [RESQ_CW:0]     inflight;
	logic                 rq_pop;
	res_t                 fin;

	// issue only when the result queue can take everything in flight
	assign inflight = (RESQ_CW + 1)'(rq_cnt_q) + (RESQ_CW + 1)'(valid_s1)
		+ (RESQ_CW + 1)'(valid_s2);
	assign opq_pop  = stat.nonempty && (inflight < (RESQ_CW + 1)'(RESQ_DEPTH));
	assign rq_pop   = pop && !empty;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= opq_pop;
			valid_s2 <= valid_s1;
		end
	end

	// stage 1: control sums
	always_ff @(posedge clk) begin
		cmd_s1 <= head.cmd;
		last_s1 <= head.last;
		n1x_s1 <= biased_sum(head.qx, head.px);
		n1y_s1 <= biased_sum(head.qy, head.py);
		n2x_s1 <= biased_sum(head.qx, head.ex);
		n2y_s1 <= biased_sum(head.qy, head.ey);
		ex_s1  <= head.ex;
		ey_s1  <= head.ey;
		tx_s1  <= head.px[15:0];
		ty_s1  <= head.py[15:0];
	end

	// stage 2: reciprocal multiplies
	assign p1x = PROD_W'(n1x_s1) * PROD_W'(RECIP6);
	assign p1y = PROD_W'(n1y_s1) * PROD_W'(RECIP6);
	assign p2x = PROD_W'(n2x_s1) * PROD_W'(RECIP6);
	assign p2y = PROD_W'(n2y_s1) * PROD_W'(RECIP6);

	always_ff @(posedge clk) begin
		cmd_s2  <= cmd_s1;
		last_s2 <= last_s1;
		q1x_s2  <= p1x[PROD_W-1:RECIP_SHIFT];
		q1y_s2  <= p1y[PROD_W-1:RECIP_SHIFT];
		q2x_s2  <= p2x[PROD_W-1:RECIP_SHIFT];
		q2y_s2  <= p2y[PROD_W-1:RECIP_SHIFT];
		l1x_s2  <= n1x_s1[2:0];
		l1y_s2  <= n1y_s1[2:0];
		l2x_s2  <= n2x_s1[2:0];
		l2y_s2  <= n2y_s1[2:0];
		ex_s2   <= ex_s1;
		ey_s2   <= ey_s1;
		tx_s2   <= tx_s1;
		ty_s2   <= ty_s1;
	end

	// rounding and result selection
	always_comb begin
		fin.cmd  = cmd_s2;
		fin.last = last_s2;
		if (cmd_s2 == CMD_CURVETO) begin
			fin.c1x = round6(q1x_s2, l1x_s2);
			fin.c1y = round6(q1y_s2, l1y_s2);
			fin.c2x = round6(q2x_s2, l2x_s2);
			fin.c2y = round6(q2y_s2, l2y_s2);
			fin.ex  = round2(ex_s2);
			fin.ey  = round2(ey_s2);
		end else begin
			fin.c1x = tx_s2;
			fin.c1y = ty_s2;
			fin.c2x = '0;
			fin.c2y = '0;
			fin.ex  = '0;
			fin.ey  = '0;
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (valid_s2) begin
			res_mem[rq_wr_q] <= fin;
		end
	end

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q  <= '0;
			rq_rd_q  <= '0;
			rq_cnt_q <= '0;
		end else begin
			if (valid_s2) begin
				rq_wr_q <= rq_wr_q + RESQ_AW'(1);
			end
			if (rq_pop) begin
				rq_rd_q <= rq_rd_q + RESQ_AW'(1);
			end
			rq_cnt_q <= rq_cnt_q + RESQ_CW'(valid_s2) - RESQ_CW'(rq_pop);
		end
	end

	assign res   = res_mem[rq_rd_q];
	assign empty = rq_cnt_q == '0;

endmodule

`default_nettype wire

[design/qoc_checker.sv]
// qoc_checker: port-level checks on the quadratic outline to cubic path unit, bound to the top
// depends on qoc_pkg and quadratic_outline_to_cubic_path_unit
`default_nettype none

module qoc_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  logic [1:0]         command,
	input  logic signed [15:0] ctrl1_x,
	input  logic signed [15:0] ctrl2_x,
	input  logic signed [15:0] ctrl2_y,
	input  logic signed [15:0] end_x,
	input  logic signed [15:0] end_y,
	input  logic               last,
	input  logic               empty,
	input  logic               pop
);
	import qoc_pkg::*;

	// moveto and lineto carry zero second control and end point
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (command == CMD_MOVETO || command == CMD_LINETO))
		|-> (ctrl2_x == 16'sd0 && ctrl2_y == 16'sd0 && end_x == 16'sd0 && end_y == 16'sd0))
	else $error("non-curve command with nonzero curve fields");

	// a waiting result holds its command, ctrl1_x and last until it is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(command) && $stable(ctrl1_x) && $stable(last)))
	else $error("waiting result changed before pop");

	// queue can only fill up after a transaction was taken in
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && !full))
	else $error("full rose without an input transaction");

endmodule

bind quadratic_outline_to_cubic_path_unit qoc_checker u_checker (.*);

`default_nettype wire

[tb/testbench.sv]
// testbench: self-checking bench for quadratic_outline_to_cubic_path_unit
// depends on qoc_pkg (command codes) and the unit itself; predicts each path command
`timescale 1ns / 1ps

module testbench;
	import qoc_pkg::*;

	localparam logic signed [15:0] COORD_MAX   = 16'sh7FFF;
	localparam logic signed [15:0] COORD_MIN   = 16'sh8000;
	localparam int                 HOLD_CYCLES = 80;
	localparam int                 QUIET_LIMIT = 2000;
	localparam int                 DRAIN_WAIT  = 12;

	// one path command as seen on the result ports
	typedef struct {
		cmd_t               cmd;
		logic signed [15:0] c1x;
		logic signed [15:0] c1y;
		logic signed [15:0] c2x;
		logic signed [15:0] c2y;
		logic signed [15:0] ex;
		logic signed [15:0] ey;
		logic               last;
	} path_cmd_t;

	logic               clk;
	logic               arst_n;
	logic signed [15:0] point_x;
	logic signed [15:0] point_y;
	logic               on_curve;
	logic               contour_end;
	logic               push;
	logic               full;
	logic [1:0]         command;
	logic signed [15:0] ctrl1_x;
	logic signed [15:0] ctrl1_y;
	logic signed [15:0] ctrl2_x;
	logic signed [15:0] ctrl2_y;
	logic signed [15:0] end_x;
	logic signed [15:0] end_y;
	logic               last;
	logic               empty;
	logic               pop;

	// contour state of the converter as the bench sees it
	logic signed [15:0] first_x, first_y;
	logic signed [16:0] anchor2_x, anchor2_y;
	logic signed [15:0] ctrl_x, ctrl_y;
	logic               ctrl_pending;
	logic               opening;

	path_cmd_t expected_path_cmds[$];

	int  error_count   = 0;
	int  points_sent   = 0;
	int  contours_sent = 0;
	int  cmds_checked  = 0;
	int  curves_seen   = 0;
	int  input_stalls  = 0;
	int  burst_left    = 1;
	bit  gaps_enabled  = 1'b1;
	bit  hold_request  = 1'b0;

	quadratic_outline_to_cubic_path_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.point_x(point_x),
		.point_y(point_y),
		.on_curve(on_curve),
		.contour_end(contour_end),
		.push(push),
		.full(full),
		.command(command),
		.ctrl1_x(ctrl1_x),
		.ctrl1_y(ctrl1_y),
		.ctrl2_x(ctrl2_x),
		.ctrl2_y(ctrl2_y),
		.end_x(end_x),
		.end_y(end_y),
		.last(last),
		.empty(empty),
		.pop(pop)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// divide and round to nearest, ties to even; den is positive
	function automatic int div_round_even(input int num, input int den);
		int q;
		int r;
		q = num / den;
		r = num % den;
		if (r < 0) begin
			q = q - 1;
			r = r + den;
		end
		if (2 * r > den || (2 * r == den && q % 2 != 0)) begin
			q = q + 1;
		end
		return q;
	endfunction

	// moveto or lineto; the anchor moves to the target
	function automatic path_cmd_t straight_cmd(input cmd_t c, input int x, input int y);
		path_cmd_t p;
		p.cmd  = c;
		p.c1x  = 16'(x);
		p.c1y  = 16'(y);
		p.c2x  = '0;
		p.c2y  = '0;
		p.ex   = '0;
		p.ey   = '0;
		p.last = 1'b0;
		anchor2_x = 17'(2 * x);
		anchor2_y = 17'(2 * y);
		return p;
	endfunction

	// cubic from the anchor through the pending control to a doubled end point
	function automatic path_cmd_t curve_cmd(input int ex2, input int ey2);
		path_cmd_t p;
		p.cmd  = CMD_CURVETO;
		p.c1x  = 16'(div_round_even(4 * int'(ctrl_x) + int'(anchor2_x), 6));
		p.c1y  = 16'(div_round_even(4 * int'(ctrl_y) + int'(anchor2_y), 6));
		p.c2x  = 16'(div_round_even(4 * int'(ctrl_x) + ex2, 6));
		p.c2y  = 16'(div_round_even(4 * int'(ctrl_y) + ey2, 6));
		p.ex   = 16'(div_round_even(ex2, 2));
		p.ey   = 16'(div_round_even(ey2, 2));
		p.last = 1'b0;
		anchor2_x = 17'(ex2);
		anchor2_y = 17'(ey2);
		return p;
	endfunction

	// work out the commands one accepted point causes and queue them
	task automatic convert_point(input logic signed [15:0] x, input logic signed [15:0] y,
			input logic on, input logic closes);
		path_cmd_t cmds[2];
		int        n;
		n = 0;
		if (opening) begin
			cmds[n] = straight_cmd(CMD_MOVETO, int'(x), int'(y));
			n++;
			first_x      = x;
			first_y      = y;
			ctrl_pending = 1'b0;
			opening      = 1'b0;
		end else if (on) begin
			if (ctrl_pending) begin
				cmds[n] = curve_cmd(2 * int'(x), 2 * int'(y));
				ctrl_pending = 1'b0;
			end else begin
				cmds[n] = straight_cmd(CMD_LINETO, int'(x), int'(y));
			end
			n++;
		end else begin
			// two controls in a row meet at their midpoint
			if (ctrl_pending) begin
				cmds[n] = curve_cmd(int'(ctrl_x) + int'(x), int'(ctrl_y) + int'(y));
				n++;
			end
			ctrl_x       = x;
			ctrl_y       = y;
			ctrl_pending = 1'b1;
		end
		// close back to the first point of the contour
		if (closes) begin
			if (ctrl_pending) begin
				cmds[n] = curve_cmd(2 * int'(first_x), 2 * int'(first_y));
			end else begin
				cmds[n] = straight_cmd(CMD_LINETO, int'(first_x), int'(first_y));
			end
			n++;
			ctrl_pending = 1'b0;
			opening      = 1'b1;
		end
		if (n > 0) begin
			cmds[n-1].last = 1'b1;
		end
		for (int i = 0; i < n; i++) begin
			expected_path_cmds.push_back(cmds[i]);
		end
	endtask

	// offer one point until taken, then maybe pause the sender
	task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
			input logic on, input logic closes);
		int gap;
		point_x     <= x;
		point_y     <= y;
		on_curve    <= on;
		contour_end <= closes;
		push        <= 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
		convert_point(x, y, on, closes);
		points_sent++;
		if (closes) contours_sent++;
		@(negedge clk);
		if (gaps_enabled) begin
			burst_left--;
			if (burst_left <= 0) begin
				gap        = $urandom_range(1, 10);
				burst_left = $urandom_range(1, 12);
				push        <= 1'b0;
				point_x     <= 16'($urandom);
				point_y     <= 16'($urandom);
				on_curve    <= 1'($urandom);
				contour_end <= 1'($urandom);
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	// coordinates: full range half the time, small values for rounding ties, extremes now and then
	function automatic logic signed [15:0] rand_coord();
		int v;
		case ($urandom_range(0, 9))
			0: return COORD_MIN;
			1: return COORD_MAX;
			2, 3, 4: begin
				v = $urandom_range(0, 8);
				return 16'(v - 4);
			end
			default: return 16'($urandom);
		endcase
	endfunction

	// one contour of random shape
	task automatic send_contour(input int len, input int off_weight);
		for (int i = 0; i < len; i++) begin
			send_point(rand_coord(), rand_coord(), $urandom_range(0, 9) >= off_weight,
				i == len - 1);
		end
	endtask

	// contours of one point, one of them with an off-curve opener, and one of three points
	task automatic test_open_and_close();
		send_point(COORD_MAX, COORD_MAX, 1'b1, 1'b1);
		send_point(COORD_MIN, 16'sd5, 1'b0, 1'b1);
		send_point(COORD_MIN, COORD_MIN, 1'b0, 1'b0);
		send_point(COORD_MAX, COORD_MIN, 1'b1, 1'b0);
		send_point(COORD_MAX, COORD_MAX, 1'b1, 1'b1);
	endtask

	// midpoint splits, closing curves and rounding ties
	task automatic test_curve_splitting();
		send_point(16'sd0, 16'sd0, 1'b1, 1'b0);
		send_point(16'sd1, 16'sd1, 1'b0, 1'b0);
		send_point(16'sd2, 16'sd2, 1'b0, 1'b0);
		send_point(-16'sd3, 16'sd5, 1'b1, 1'b0);
		send_point(16'sd7, -16'sd7, 1'b0, 1'b1);
		// off-curve point ends the contour with a control pending
		send_point(16'sd10, 16'sd10, 1'b1, 1'b0);
		send_point(16'sd3, -16'sd7, 1'b0, 1'b0);
		send_point(-16'sd5, 16'sd1, 1'b0, 1'b1);
	endtask

	// curves spanning the whole coordinate range
	task automatic test_coordinate_extremes();
		send_point(COORD_MAX, COORD_MIN, 1'b1, 1'b0);
		send_point(COORD_MIN, COORD_MAX, 1'b0, 1'b0);
		send_point(COORD_MAX, COORD_MAX, 1'b0, 1'b0);
		send_point(COORD_MIN, COORD_MIN, 1'b0, 1'b1);
	endtask

	// well-formed contours, about one in four sent without pauses
	task automatic test_random_outlines(input int num_points);
		int start;
		int len;
		start = points_sent;
		while (points_sent - start < num_points) begin
			gaps_enabled = ($urandom_range(0, 3) != 0);
			len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 9);
			send_contour(len, $urandom_range(2, 6));
		end
		gaps_enabled = 1'b1;
	endtask

	// stray points with random flags, contours cut at random
	task automatic test_stray_points(input int num_points);
		for (int i = 0; i < num_points; i++) begin
			send_point(16'($urandom), 16'($urandom), 1'($urandom),
				$urandom_range(0, 3) == 0);
		end
	endtask

	// receiver holds off while points keep coming, so full must rise
	task automatic test_output_stall();
		gaps_enabled = 1'b0;
		hold_request = 1'b1;
		send_contour(12, 3);
		send_contour(10, 5);
		send_contour(8, 0);
		gaps_enabled = 1'b1;
	endtask

	// stimulus
	initial begin
		push        = 1'b0;
		point_x     = '0;
		point_y     = '0;
		on_curve    = 1'b0;
		contour_end = 1'b0;
		first_x      = '0;
		first_y      = '0;
		anchor2_x    = '0;
		anchor2_y    = '0;
		ctrl_x       = '0;
		ctrl_y       = '0;
		ctrl_pending = 1'b0;
		opening      = 1'b1;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_open_and_close();
		test_curve_splitting();
		test_coordinate_extremes();
		test_random_outlines(200);
		test_output_stall();
		test_stray_points(60);
		test_random_outlines(130);

		push <= 1'b0;
		while (expected_path_cmds.size() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);

		$display("Run covered %0d points in %0d closed contours, %0d path commands (%0d curves);",
			points_sent, contours_sent, cmds_checked, curves_seen);
		$display("the sender was held off by a full queue in %0d cycles", input_stalls);
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// result side: stall modes change at random, plus one long hold-off on request
	initial begin : receiver
		int mode;
		int mode_left;
		int hold_left;
		int tick;
		pop       = 1'b0;
		mode      = 0;
		mode_left = 0;
		hold_left = 0;
		tick      = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			tick++;
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				case (mode)
					0: pop <= 1'b1;
					1: pop <= 1'($urandom_range(0, 1));
					2: pop <= ($urandom_range(0, 3) == 0);
					default: pop <= ((tick / 3) % 2 == 0);
				endcase
			end
		end
	end

	task automatic check_field(input string name, input logic signed [16:0] want,
			input logic signed [16:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	// compare every result transaction with the oldest expected command
	always @(posedge clk) begin : result_check
		path_cmd_t want;
		if (arst_n && pop && !empty) begin
			if (expected_path_cmds.size() == 0) begin
				$error("result with no command expected: command %0d", command);
				error_count++;
			end else begin
				want = expected_path_cmds.pop_front();
				check_field("command", 17'(want.cmd), 17'(command));
				check_field("ctrl1_x", 17'(want.c1x), 17'(ctrl1_x));
				check_field("ctrl1_y", 17'(want.c1y), 17'(ctrl1_y));
				check_field("ctrl2_x", 17'(want.c2x), 17'(ctrl2_x));
				check_field("ctrl2_y", 17'(want.c2y), 17'(ctrl2_y));
				check_field("end_x", 17'(want.ex), 17'(end_x));
				check_field("end_y", 17'(want.ey), 17'(end_y));
				check_field("last", 17'(want.last), 17'(last));
				cmds_checked++;
				if (want.cmd == CMD_CURVETO) curves_seen++;
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
			if (arst_n && push && full) input_stalls++;
		end
		$display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
		$display("Verification failed");
		$finish;
	end

endmodule
